// ===== rtl/e2c_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the cube sample coordinate block.
package e2c_pkg;

  localparam int STAGES       = 16;
  localparam int MAX_FS       = 1024;
  localparam int XW           = 36;
  localparam int ZW           = 34;
  localparam int PRESCALE_SH  = 20;
  localparam int OUT_DEPTH    = 64;
  localparam int OUT_AW       = 6;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  localparam logic [29:0] KINV_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [34:0]   HALF_TURN_W  = 35'sd2147483648;
  localparam logic signed [34:0]   QUARTER_W    = 35'sd1073741824;

  localparam logic CFG_SRC_WIDTH  = 1'b0;
  localparam logic CFG_SRC_HEIGHT = 1'b1;

  localparam logic [2:0] FACE_0 = 3'd0;
  localparam logic [2:0] FACE_1 = 3'd1;
  localparam logic [2:0] FACE_2 = 3'd2;
  localparam logic [2:0] FACE_3 = 3'd3;
  localparam logic [2:0] FACE_4 = 3'd4;
  localparam logic [2:0] FACE_5 = 3'd5;

  typedef struct packed {
    logic [10:0] fs;
    logic [11:0] cw;
    logic [10:0] ch;
  } cfg_t;

  typedef struct packed {
    logic [11:0]           dest_x;
    logic [11:0]           dest_y;
    logic signed [XW-1:0]  z;
    logic signed [ZW-1:0]  theta;
  } meta_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    meta_t                meta;
  } work_t;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] tap_u_low;
    logic [11:0] tap_u_high;
    logic [10:0] tap_v_low;
    logic [10:0] tap_v_high;
    logic [15:0] weight_u;
    logic [15:0] weight_v;
  } res_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int k);
    logic signed [ZW-1:0] t;
    case (k)
      0:  t = 34'sd536870912;
      1:  t = 34'sd316933406;
      2:  t = 34'sd167458907;
      3:  t = 34'sd85004756;
      4:  t = 34'sd42667331;
      5:  t = 34'sd21354465;
      6:  t = 34'sd10679838;
      7:  t = 34'sd5340245;
      8:  t = 34'sd2670163;
      9:  t = 34'sd1335087;
      10: t = 34'sd667544;
      11: t = 34'sd333772;
      12: t = 34'sd166886;
      13: t = 34'sd83443;
      14: t = 34'sd41722;
      15: t = 34'sd20861;
      16: t = 34'sd10430;
      17: t = 34'sd5215;
      18: t = 34'sd2608;
      19: t = 34'sd1304;
      20: t = 34'sd652;
      21: t = 34'sd326;
      22: t = 34'sd163;
      23: t = 34'sd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/e2c_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, face decode and cube direction forming.
module e2c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic [2:0]          face,
  input  logic [9:0]          col,
  input  logic [9:0]          row,
  output e2c_pkg::cfg_t       cfg,
  output e2c_pkg::work_t      item
);

  logic [12:0] width_r;
  logic [11:0] height_r;
  logic [10:0] w4;
  logic [10:0] fs;
  logic signed [11:0] a, b, fsn;
  logic signed [11:0] dx, dy, dz;
  logic [11:0] offx, offy, fs2, fs3;

  function automatic logic signed [e2c_pkg::XW-1:0] scale(input logic signed [11:0] v);
    logic signed [e2c_pkg::XW-1:0] e;
    e = $signed({{(e2c_pkg::XW-12){v[11]}}, v});
    return e <<< e2c_pkg::PRESCALE_SH;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd4096;
      height_r <= 12'd2048;
    end else if (cfg_valid) begin
      if (cfg_index == e2c_pkg::CFG_SRC_WIDTH) width_r <= cfg_data;
      else height_r <= cfg_data[11:0];
    end
  end

  always_comb begin
    w4 = width_r[12:2];
    if (w4 > 11'(e2c_pkg::MAX_FS)) fs = 11'(e2c_pkg::MAX_FS);
    else if (w4 == 11'd0) fs = 11'd1;
    else fs = w4;
    cfg.fs = fs;
    if (width_r > 13'd4096) cfg.cw = 12'd4095;
    else if (width_r == 13'd0) cfg.cw = 12'd0;
    else cfg.cw = 12'(width_r - 13'd1);
    if (height_r > 12'd2048) cfg.ch = 11'd2047;
    else if (height_r == 12'd0) cfg.ch = 11'd0;
    else cfg.ch = 11'(height_r - 12'd1);
  end

  always_comb begin
    fsn = $signed({1'b0, fs});
    a   = $signed({1'b0, col, 1'b0}) - fsn;
    b   = $signed({1'b0, row, 1'b0}) - fsn;
    fs2 = {fs, 1'b0};
    fs3 = {fs, 1'b0} + {1'b0, fs};
    dx = '0; dy = '0; dz = '0; offx = '0; offy = '0;
    unique case (face)
      e2c_pkg::FACE_0: begin dx = -fsn; dy = a;    dz = b;    offx = {1'b0, fs}; offy = fs3; end
      e2c_pkg::FACE_1: begin dx = a;    dy = -fsn; dz = -b;   offx = '0;         offy = {1'b0, fs}; end
      e2c_pkg::FACE_2: begin dx = fsn;  dy = a;    dz = -b;   offx = {1'b0, fs}; offy = {1'b0, fs}; end
      e2c_pkg::FACE_3: begin dx = -a;   dy = fsn;  dz = -b;   offx = fs2;        offy = {1'b0, fs}; end
      e2c_pkg::FACE_4: begin dx = b;    dy = a;    dz = fsn;  offx = {1'b0, fs}; offy = '0; end
      e2c_pkg::FACE_5: begin dx = -b;   dy = a;    dz = -fsn; offx = {1'b0, fs}; offy = fs2; end
      default: begin dx = '0; dy = '0; dz = '0; offx = '0; offy = '0; end
    endcase
    item.x = scale(dx);
    item.y = scale(dy);
    item.meta.z = scale(dz);
    item.meta.theta = '0;
    item.meta.dest_x = {2'b00, col} + offx;
    item.meta.dest_y = {2'b00, row} + offy;
  end

endmodule

// ===== rtl/e2c_queue.sv =====
`timescale 1ns / 1ps
// Short queue between front and back end.
module e2c_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  e2c_pkg::work_t  wr_data,
  input  logic            rd_en,
  output e2c_pkg::work_t  rd_data,
  output logic            full,
  output logic            empty
);

  e2c_pkg::work_t mem_r [0:e2c_pkg::Q_DEPTH-1];
  logic [e2c_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [e2c_pkg::Q_AW:0]   cnt_r;

  assign full    = cnt_r == (e2c_pkg::Q_AW+1)'(e2c_pkg::Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (e2c_pkg::Q_AW+1)'(wr_en) - (e2c_pkg::Q_AW+1)'(rd_en);
    end
  end

endmodule

// ===== rtl/e2c_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: angle in 2^-32 turn and gained magnitude.
module e2c_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [e2c_pkg::XW-1:0]     in_x,
  input  logic signed [e2c_pkg::XW-1:0]     in_y,
  input  e2c_pkg::meta_t                    in_meta,
  output logic                              out_valid,
  output logic signed [e2c_pkg::ZW-1:0]     out_ang,
  output logic signed [e2c_pkg::XW-1:0]     out_mag,
  output e2c_pkg::meta_t                    out_meta
);

  localparam int N = e2c_pkg::STAGES;

  logic signed [e2c_pkg::XW-1:0] x_r [0:N];
  logic signed [e2c_pkg::XW-1:0] y_r [0:N];
  logic signed [e2c_pkg::ZW-1:0] z_r [0:N];
  e2c_pkg::meta_t                m_r [0:N];
  logic [N:0] v_r;
  logic [N:0] zf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[N-1:0], in_valid};
  end

  always_ff @(posedge clk) begin
    zf_r[0] <= (in_x == '0) && (in_y == '0);
    m_r[0]  <= in_meta;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        x_r[0] <= in_y;
        y_r[0] <= -in_x;
        z_r[0] <= e2c_pkg::QUARTER_TURN;
      end else begin
        x_r[0] <= -in_y;
        y_r[0] <= in_x;
        z_r[0] <= -e2c_pkg::QUARTER_TURN;
      end
    end else begin
      x_r[0] <= in_x;
      y_r[0] <= in_y;
      z_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      zf_r[k+1] <= zf_r[k];
      m_r[k+1]  <= m_r[k];
      if (y_r[k] > 0) begin
        x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] + e2c_pkg::atan_turn(k);
      end else begin
        x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
        y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
        z_r[k+1] <= z_r[k] - e2c_pkg::atan_turn(k);
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_ang   = zf_r[N] ? '0 : z_r[N];
  assign out_mag   = zf_r[N] ? '0 : x_r[N];
  assign out_meta  = m_r[N];

endmodule

// ===== rtl/e2c_back.sv =====
`timescale 1ns / 1ps
// Back end: two CORDIC passes, gain correction, source mapping and result queue.
module e2c_back (
  input  logic            clk,
  input  logic            rst_n,
  input  e2c_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  e2c_pkg::work_t  q_data,
  output logic            q_rd,
  input  logic            pop,
  output logic            empty,
  output e2c_pkg::res_t   res
);

  localparam int OCW = e2c_pkg::OUT_AW + 1;

  logic [OCW-1:0] total_r, mcnt_r;
  logic [e2c_pkg::OUT_AW-1:0] wp_r, rp_r;
  logic ov_r, mem_rd, mem_wr, out_pop;
  e2c_pkg::res_t mem_r [0:e2c_pkg::OUT_DEPTH-1];
  e2c_pkg::res_t out_r, wr_res;

  logic c1_v, c2_v;
  logic signed [e2c_pkg::ZW-1:0] c1_ang, c2_ang;
  logic signed [e2c_pkg::XW-1:0] c1_mag, c2_mag;
  e2c_pkg::meta_t c1_meta, c2_meta, c1_meta_th;

  logic m1_v_r, m2_v_r, u1_v_r, u2_v_r;
  logic [46:0] ph_r, pl_r;
  e2c_pkg::meta_t m1_meta_r, m2_meta_r;
  logic signed [e2c_pkg::XW-1:0] r_r;
  logic [63:0] rsum;
  logic [11:0] u1_dx_r, u1_dy_r, u2_dx_r, u2_dy_r;
  logic signed [48:0] uf_r, vf_r, uf2_r, vf2_r;
  logic signed [16:0] uq, vq;
  logic [11:0] ulo, uhi, ulo_r, uhi_r;
  logic [10:0] vlo, vhi, vlo_r, vhi_r;
  logic signed [48:0] du, dv;
  logic signed [32:0] su, sv;
  logic signed [13:0] fs4;

  assign q_rd    = !q_empty && (total_r < OCW'(e2c_pkg::OUT_DEPTH));
  assign out_pop = pop && ov_r;
  assign empty   = !ov_r;
  assign res     = out_r;

  e2c_cordic u_cordic_xy (
    .clk(clk), .rst_n(rst_n), .in_valid(q_rd), .in_x(q_data.x), .in_y(q_data.y),
    .in_meta(q_data.meta), .out_valid(c1_v), .out_ang(c1_ang), .out_mag(c1_mag),
    .out_meta(c1_meta)
  );

  always_comb begin
    c1_meta_th       = c1_meta;
    c1_meta_th.theta = c1_ang;
  end

  assign rsum = {ph_r, 17'd0} + {17'd0, pl_r};

  always_ff @(posedge clk) begin
    ph_r      <= c1_mag[33:17] * e2c_pkg::KINV_Q30;
    pl_r      <= c1_mag[16:0] * e2c_pkg::KINV_Q30;
    m1_meta_r <= c1_meta_th;
    r_r       <= $signed({2'b00, rsum[63:30]});
    m2_meta_r <= m1_meta_r;
  end

  e2c_cordic u_cordic_rz (
    .clk(clk), .rst_n(rst_n), .in_valid(m2_v_r), .in_x(r_r), .in_y(m2_meta_r.z),
    .in_meta(m2_meta_r), .out_valid(c2_v), .out_ang(c2_ang), .out_mag(c2_mag),
    .out_meta(c2_meta)
  );

  assign fs4 = $signed({1'b0, cfg.fs, 2'b00});

  always_ff @(posedge clk) begin
    uf_r    <= ($signed({c2_meta.theta[e2c_pkg::ZW-1], c2_meta.theta}) + e2c_pkg::HALF_TURN_W)
               * fs4;
    vf_r    <= (e2c_pkg::QUARTER_W - $signed({c2_ang[e2c_pkg::ZW-1], c2_ang})) * fs4;
    u1_dx_r <= c2_meta.dest_x;
    u1_dy_r <= c2_meta.dest_y;
  end

  always_comb begin
    uq = uf_r[48:32];
    vq = vf_r[48:32];
    if (uq < 0) ulo = '0;
    else if (uq > $signed({5'd0, cfg.cw})) ulo = cfg.cw;
    else ulo = uq[11:0];
    uhi = (ulo == cfg.cw) ? cfg.cw : ulo + 12'd1;
    if (vq < 0) vlo = '0;
    else if (vq > $signed({6'd0, cfg.ch})) vlo = cfg.ch;
    else vlo = vq[10:0];
    vhi = (vlo == cfg.ch) ? cfg.ch : vlo + 11'd1;
  end

  always_ff @(posedge clk) begin
    ulo_r   <= ulo;
    uhi_r   <= uhi;
    vlo_r   <= vlo;
    vhi_r   <= vhi;
    uf2_r   <= uf_r;
    vf2_r   <= vf_r;
    u2_dx_r <= u1_dx_r;
    u2_dy_r <= u1_dy_r;
  end

  always_comb begin
    du = uf2_r - $signed({5'd0, ulo_r, 32'd0});
    dv = vf2_r - $signed({6'd0, vlo_r, 32'd0});
    su = du[48:16];
    sv = dv[48:16];
    wr_res.dest_x     = u2_dx_r;
    wr_res.dest_y     = u2_dy_r;
    wr_res.tap_u_low  = ulo_r;
    wr_res.tap_u_high = uhi_r;
    wr_res.tap_v_low  = vlo_r;
    wr_res.tap_v_high = vhi_r;
    if (su < 0) wr_res.weight_u = '0;
    else if (su > 33'sd65535) wr_res.weight_u = 16'hFFFF;
    else wr_res.weight_u = su[15:0];
    if (sv < 0) wr_res.weight_v = '0;
    else if (sv > 33'sd65535) wr_res.weight_v = 16'hFFFF;
    else wr_res.weight_v = sv[15:0];
  end

  assign mem_wr = u2_v_r;
  assign mem_rd = (mcnt_r != '0) && (!ov_r || out_pop);

  always_ff @(posedge clk) begin
    if (mem_wr) mem_r[wp_r] <= wr_res;
    if (mem_rd) out_r <= mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      u1_v_r  <= 1'b0;
      u2_v_r  <= 1'b0;
      wp_r    <= '0;
      rp_r    <= '0;
      mcnt_r  <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      m1_v_r  <= c1_v;
      m2_v_r  <= m1_v_r;
      u1_v_r  <= c2_v;
      u2_v_r  <= u1_v_r;
      if (mem_wr) wp_r <= wp_r + 1'b1;
      if (mem_rd) rp_r <= rp_r + 1'b1;
      mcnt_r  <= mcnt_r + OCW'(mem_wr) - OCW'(mem_rd);
      total_r <= total_r + OCW'(q_rd) - OCW'(out_pop);
      if (mem_rd) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= OCW'(e2c_pkg::OUT_DEPTH))
    else $error("result credit count overflow");

  a_stored_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (mcnt_r + OCW'(ov_r)) <= total_r)
    else $error("stored beats exceed issued beats");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> (mcnt_r < OCW'(e2c_pkg::OUT_DEPTH)))
    else $error("result memory written while full");

endmodule

// ===== rtl/equirect_to_cube_sample_coords.sv =====
`timescale 1ns / 1ps
// Top level: cube pixel to equirectangular bilinear sample coordinates.
//
//   channel | handshake            | beat
//   input   | push / full          | in_face, in_col, in_row
//   result  | empty / pop          | out_dest_x .. out_weight_v
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while result credits remain and results are popped; a result
// passes through the two 17-stage CORDIC pipelines plus gain, mapping and the result memory.
// The result memory holds 64 beats; issue from the queue stops when all are claimed.
// Synchronous active-low reset; src_width 4096 and src_height 2048 after reset.
// full rises when the 4-entry queue is full; it does not look at the result credits directly.
module equirect_to_cube_sample_coords (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_face,
  input  logic [9:0]  in_col,
  input  logic [9:0]  in_row,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] out_dest_x,
  output logic [11:0] out_dest_y,
  output logic [11:0] out_tap_u_low,
  output logic [11:0] out_tap_u_high,
  output logic [10:0] out_tap_v_low,
  output logic [10:0] out_tap_v_high,
  output logic [15:0] out_weight_u,
  output logic [15:0] out_weight_v,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  e2c_pkg::cfg_t  cfg;
  e2c_pkg::work_t item, q_data;
  e2c_pkg::res_t  res;
  logic q_full, q_empty, q_rd;

  assign full = q_full;

  e2c_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .face(in_face), .col(in_col),
    .row(in_row), .cfg(cfg), .item(item)
  );

  e2c_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(push && !q_full), .wr_data(item),
    .rd_en(q_rd), .rd_data(q_data), .full(q_full), .empty(q_empty)
  );

  e2c_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_empty(q_empty), .q_data(q_data),
    .q_rd(q_rd), .pop(pop), .empty(empty), .res(res)
  );

  assign out_dest_x     = res.dest_x;
  assign out_dest_y     = res.dest_y;
  assign out_tap_u_low  = res.tap_u_low;
  assign out_tap_u_high = res.tap_u_high;
  assign out_tap_v_low  = res.tap_v_low;
  assign out_tap_v_high = res.tap_v_high;
  assign out_weight_u   = res.weight_u;
  assign out_weight_v   = res.weight_v;

endmodule
